/* sv/dstwr_pkg.sv */
// ============================================================================
// dstwr_pkg: shared types and codes for the two-way ranging responder
// Event and result payloads, frame stage codes and action codes.
// ============================================================================
package dstwr_pkg;

	localparam int unsigned STAMP_W = 40;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned ADDR_W  = 8;

	// event kinds
	localparam logic [1:0] KIND_RX_GOOD = 2'd0;
	localparam logic [1:0] KIND_RX_ERR  = 2'd1;
	localparam logic [1:0] KIND_TX_DONE = 2'd2;

	// frame stage codes
	localparam logic [2:0] STG_NONE   = 3'd0;
	localparam logic [2:0] STG_POLL   = 3'd1;
	localparam logic [2:0] STG_RESP   = 3'd2;
	localparam logic [2:0] STG_FINAL  = 3'd3;
	localparam logic [2:0] STG_REPORT = 3'd4;
	localparam logic [2:0] STG_BCAST  = 3'd5;

	// ordered actions
	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_REARM  = 2'd1;
	localparam logic [1:0] ACT_RESP   = 2'd2;
	localparam logic [1:0] ACT_REPORT = 2'd3;

	localparam logic [ADDR_W-1:0] OWN_ADDR_RST = 8'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         rx_stage;
		logic [ADDR_W-1:0]  rx_dest;
		logic [ADDR_W-1:0]  rx_sender;
		logic [STAMP_W-1:0] stamp;
	} ev_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [ADDR_W-1:0] tx_dest;
		logic [2:0]        tx_stage;
		logic [TIME_W-1:0] round_time;
		logic [TIME_W-1:0] reply_time;
		logic [TIME_W-1:0] ranges_done;
		logic [TIME_W-1:0] error_total;
	} res_t;

	// input stage to engine
	typedef struct packed {
		logic valid;
		ev_t  ev;
	} slot_t;

endpackage

/* sv/dstwr_radio_if.sv */
// ============================================================================
// dstwr_radio_if: radio event channel
// Valid/ready channel carrying one radio event per beat.
// ============================================================================
interface dstwr_radio_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    kind;
	logic [2:0]                    rx_stage;
	logic [dstwr_pkg::ADDR_W-1:0]  rx_dest;
	logic [dstwr_pkg::ADDR_W-1:0]  rx_sender;
	logic [dstwr_pkg::STAMP_W-1:0] stamp;

	modport source (output valid, kind, rx_stage, rx_dest, rx_sender, stamp, input ready);
	modport sink   (input valid, kind, rx_stage, rx_dest, rx_sender, stamp, output ready);
endinterface

/* sv/dstwr_cmd_if.sv */
// ============================================================================
// dstwr_cmd_if: responder command channel
// Valid/ready channel carrying one ordered action and its times per beat.
// ============================================================================
interface dstwr_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic [dstwr_pkg::ADDR_W-1:0] tx_dest;
	logic [2:0]                   tx_stage;
	logic [dstwr_pkg::TIME_W-1:0] round_time;
	logic [dstwr_pkg::TIME_W-1:0] reply_time;
	logic [dstwr_pkg::TIME_W-1:0] ranges_done;
	logic [dstwr_pkg::TIME_W-1:0] error_total;

	modport source (output valid, action, tx_dest, tx_stage, round_time, reply_time,
		ranges_done, error_total, input ready);
	modport sink   (input valid, action, tx_dest, tx_stage, round_time, reply_time,
		ranges_done, error_total, output ready);
endinterface

/* sv/dstwr_in_stage.sv */
// ============================================================================
// dstwr_in_stage: event input register
// Captures one accepted event beat and holds it until the engine consumes it.
// ============================================================================
module dstwr_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             advance,
	input  dstwr_pkg::ev_t   ev,
	output dstwr_pkg::slot_t slot
);

	logic           valid_s1;
	dstwr_pkg::ev_t ev_s1;

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			ev_s1 <= ev;
		end
	end

	assign slot.valid = valid_s1;
	assign slot.ev    = ev_s1;

endmodule

/* sv/dstwr_engine.sv */
// ============================================================================
// dstwr_engine: ranging exchange state and per-event decision
// Holds the exchange phase, tag, time stamps and counters; decides the
// action for the event in the input register combinationally.
// ============================================================================
module dstwr_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [dstwr_pkg::ADDR_W-1:0] cfg_wr_data,
	input  dstwr_pkg::slot_t             slot,
	input  logic                         advance,
	output dstwr_pkg::res_t              res
);

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_WAIT_TX    = 2'd1,
		PH_WAIT_FINAL = 2'd2
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic [dstwr_pkg::ADDR_W-1:0]    anchor_q;
	logic [dstwr_pkg::ADDR_W-1:0]    tag_q, tag_d;
	logic [dstwr_pkg::STAMP_W-1:0]   poll_rx_q, poll_rx_d;
	logic [dstwr_pkg::STAMP_W-1:0]   resp_tx_q, resp_tx_d;
	logic [dstwr_pkg::TIME_W-1:0]    reply_q, reply_d;
	logic [dstwr_pkg::TIME_W-1:0]    range_cnt_q, range_cnt_d;
	logic [dstwr_pkg::TIME_W-1:0]    err_cnt_q, err_cnt_d;
	logic [dstwr_pkg::STAMP_W-1:0]   since_poll, since_resp;
	logic                            to_me;
	dstwr_pkg::ev_t                  ev;

	assign ev    = slot.ev;
	assign to_me = (ev.rx_dest == anchor_q);

	// modulo 2^40 differences
	assign since_poll = ev.stamp - poll_rx_q;
	assign since_resp = ev.stamp - resp_tx_q;

	// per-event decision
	always_comb begin
		phase_d     = phase_q;
		tag_d       = tag_q;
		poll_rx_d   = poll_rx_q;
		resp_tx_d   = resp_tx_q;
		reply_d     = reply_q;
		range_cnt_d = range_cnt_q;
		err_cnt_d   = err_cnt_q;

		res.action     = dstwr_pkg::ACT_NONE;
		res.tx_dest    = '0;
		res.tx_stage   = dstwr_pkg::STG_NONE;
		res.round_time = '0;
		res.reply_time = '0;

		case (ev.kind)
			dstwr_pkg::KIND_RX_GOOD: begin
				res.action = dstwr_pkg::ACT_REARM;
				if (ev.rx_stage == dstwr_pkg::STG_BCAST) begin
					// broadcast: rearm only
				end else if (ev.rx_stage == dstwr_pkg::STG_POLL && to_me) begin
					tag_d        = ev.rx_sender;
					poll_rx_d    = ev.stamp;
					reply_d      = '0;
					phase_d      = PH_WAIT_TX;
					res.action   = dstwr_pkg::ACT_RESP;
					res.tx_dest  = ev.rx_sender;
					res.tx_stage = dstwr_pkg::STG_RESP;
				end else if (ev.rx_stage == dstwr_pkg::STG_FINAL && to_me
						&& phase_q == PH_WAIT_FINAL) begin
					phase_d = PH_IDLE;
					if (ev.rx_sender == tag_q) begin
						range_cnt_d    = range_cnt_q + 1'b1;
						res.action     = dstwr_pkg::ACT_REPORT;
						res.tx_dest    = tag_q;
						res.tx_stage   = dstwr_pkg::STG_REPORT;
						res.round_time = since_resp[dstwr_pkg::TIME_W-1:0];
						res.reply_time = reply_q;
					end
				end
			end
			dstwr_pkg::KIND_RX_ERR: begin
				err_cnt_d  = err_cnt_q + 1'b1;
				res.action = dstwr_pkg::ACT_REARM;
			end
			dstwr_pkg::KIND_TX_DONE: begin
				if (phase_q == PH_WAIT_TX) begin
					resp_tx_d = ev.stamp;
					reply_d   = since_poll[dstwr_pkg::TIME_W-1:0];
					phase_d   = PH_WAIT_FINAL;
				end
			end
			default: begin
				// unused kind: no action
			end
		endcase

		res.ranges_done = range_cnt_d;
		res.error_total = err_cnt_d;
	end

	// exchange state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q    <= dstwr_pkg::OWN_ADDR_RST;
			phase_q     <= PH_IDLE;
			tag_q       <= '0;
			poll_rx_q   <= '0;
			resp_tx_q   <= '0;
			reply_q     <= '0;
			range_cnt_q <= '0;
			err_cnt_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				anchor_q <= cfg_wr_data;
			end
			if (advance) begin
				phase_q     <= phase_d;
				tag_q       <= tag_d;
				poll_rx_q   <= poll_rx_d;
				resp_tx_q   <= resp_tx_d;
				reply_q     <= reply_d;
				range_cnt_q <= range_cnt_d;
				err_cnt_q   <= err_cnt_d;
			end
		end
	end

	// checks
	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ev.kind == dstwr_pkg::KIND_RX_ERR |=> err_cnt_q == $past(err_cnt_q) + 1'b1)
		else $error("error count did not step on receive error");

	a_range_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.action == dstwr_pkg::ACT_REPORT
		|=> range_cnt_q == $past(range_cnt_q) + 1'b1 && phase_q == PH_IDLE)
		else $error("report without range count step or return to idle");

	a_resp_phase: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.action == dstwr_pkg::ACT_RESP |=> phase_q == PH_WAIT_TX)
		else $error("response ordered but not awaiting its send time");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(range_cnt_q) && $stable(err_cnt_q))
		else $error("exchange state moved without an event");

endmodule

/* sv/dstwr_out_stage.sv */
// ============================================================================
// dstwr_out_stage: result register
// Holds one result beat until the command channel takes it.
// ============================================================================
module dstwr_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  dstwr_pkg::res_t res,
	input  logic            out_ready,
	output logic            out_valid,
	output logic            space,
	output dstwr_pkg::res_t res_q
);

	logic valid_q;

	// room when empty or draining this cycle
	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

/* sv/ds_twr_responder.sv */
// ============================================================================
// ds_twr_responder: double-sided two-way ranging responder
// Turns radio events into response/report orders and ranging times.
// ============================================================================
//
// channel   dir  beat contents
// --------  ---  ------------------------------------------------------------
// radio     in   kind, rx_stage, rx_dest, rx_sender, stamp
// cmd       out  action, tx_dest, tx_stage, round_time, reply_time, counters
// cfg_wr_*  in   own frame address, written whenever cfg_wr_en is high
//
// One event per cycle sustained while cmd is not stalled; each result is offered
// on cmd after its event beat passes the input register, then the result register.
// The combinational decision step against the stored exchange state sets the rate.
// Reset clears phase, stamps and counters; the own address returns to 3.
// A stalled cmd channel backs up through the input register to radio.ready.
// ============================================================================
module ds_twr_responder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [dstwr_pkg::ADDR_W-1:0] cfg_wr_data,
	dstwr_radio_if.sink                  radio,
	dstwr_cmd_if.source                  cmd
);

	dstwr_pkg::ev_t   ev;
	dstwr_pkg::slot_t slot;
	dstwr_pkg::res_t  res, res_q;
	logic             space, advance, load;

	// pack the event beat
	assign ev.kind      = radio.kind;
	assign ev.rx_stage  = radio.rx_stage;
	assign ev.rx_dest   = radio.rx_dest;
	assign ev.rx_sender = radio.rx_sender;
	assign ev.stamp     = radio.stamp;

	// flow control
	assign advance     = slot.valid && space;
	assign radio.ready = !slot.valid || advance;
	assign load        = radio.valid && radio.ready;

	dstwr_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.advance (advance),
		.ev      (ev),
		.slot    (slot)
	);

	dstwr_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.slot        (slot),
		.advance     (advance),
		.res         (res)
	);

	dstwr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.out_ready (cmd.ready),
		.out_valid (cmd.valid),
		.space     (space),
		.res_q     (res_q)
	);

	// unpack the result beat
	assign cmd.action      = res_q.action;
	assign cmd.tx_dest     = res_q.tx_dest;
	assign cmd.tx_stage    = res_q.tx_stage;
	assign cmd.round_time  = res_q.round_time;
	assign cmd.reply_time  = res_q.reply_time;
	assign cmd.ranges_done = res_q.ranges_done;
	assign cmd.error_total = res_q.error_total;

endmodule
